/* hw/rtl/taylor_exp_approximator_assert.svh */
// Assertion macros for the exp Taylor-series block.
// Used by taylor_exp_approximator.sv; no other dependencies.
`ifndef TAYLOR_EXP_APPROXIMATOR_ASSERT_SVH
`define TAYLOR_EXP_APPROXIMATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TEA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TEA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/tea_pkg.sv */
// Types, constants, reciprocal table and microcode ROM for the exp Taylor-series block.
// No dependencies; used by taylor_exp_approximator.sv.
`timescale 1ns / 1ps

package tea_pkg;

	// Number format and series limits
	localparam int FRAC_BITS = 24;
	localparam int MAX_TERMS = 32;
	localparam int X_W       = 32;
	localparam int TERM_W    = 64;
	localparam int CNT_W     = 6;
	localparam int K_W       = $clog2(MAX_TERMS + 1);
	localparam int RCP_W     = 32;
	localparam int RCP_FRAC  = 31;

	// Datapath widths derived from the format
	localparam int P1_W  = TERM_W + X_W - FRAC_BITS;   // term*x after rounding shift
	localparam int MA_W  = (P1_W + 1) / 2;             // multiplier operand A
	localparam int MP_W  = MA_W + RCP_W;               // multiplier product
	localparam int ACC_W = MP_W + 1;
	localparam int S1_W  = MP_W + X_W + 1;
	localparam int S2_W  = MP_W + MA_W + 1;
	localparam int Q_W   = S2_W - RCP_FRAC;

	// Microcode program
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_START = PC_W'(0);
	localparam logic [PC_W-1:0] PC_LOOP  = PC_W'(1);
	localparam logic [PC_W-1:0] PC_FIN   = PC_W'(8);

	typedef struct packed {
		logic signed [X_W-1:0] arg_x;
		logic [CNT_W-1:0]      term_count;
	} tea_req_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] approx;
		logic                     count_error;
		logic                     overflowed;
	} tea_rsp_t;

	// Multiplier operand selection
	typedef enum logic [2:0] {
		MUL_NONE = 3'd0,
		MUL_TLO  = 3'd1,
		MUL_THI  = 3'd2,
		MUL_PLO  = 3'd3,
		MUL_PHI  = 3'd4
	} tea_mul_t;

	// Adder operation
	typedef enum logic [2:0] {
		ALU_NONE    = 3'd0,
		ALU_LOAD_TX = 3'd1,
		ALU_ADD_TX  = 3'd2,
		ALU_LOAD_RC = 3'd3,
		ALU_ADD_RC  = 3'd4
	} tea_alu_t;

	typedef struct packed {
		tea_mul_t mul;
		tea_alu_t alu;
		logic     term_en;
		logic     sum_en;
		logic     loop;
		logic     fin;
	} tea_cw_t;

	// Q1.31 reciprocal round(2^31/k); k = 0 unused
	function automatic logic [RCP_W-1:0] tea_recip(input logic [K_W-1:0] k);
		logic [RCP_W-1:0] r;
		case (k)
			K_W'(1):  r = 32'd2147483648;
			K_W'(2):  r = 32'd1073741824;
			K_W'(3):  r = 32'd715827883;
			K_W'(4):  r = 32'd536870912;
			K_W'(5):  r = 32'd429496730;
			K_W'(6):  r = 32'd357913941;
			K_W'(7):  r = 32'd306783378;
			K_W'(8):  r = 32'd268435456;
			K_W'(9):  r = 32'd238609294;
			K_W'(10): r = 32'd214748365;
			K_W'(11): r = 32'd195225786;
			K_W'(12): r = 32'd178956971;
			K_W'(13): r = 32'd165191050;
			K_W'(14): r = 32'd153391689;
			K_W'(15): r = 32'd143165577;
			K_W'(16): r = 32'd134217728;
			K_W'(17): r = 32'd126322568;
			K_W'(18): r = 32'd119304647;
			K_W'(19): r = 32'd113025455;
			K_W'(20): r = 32'd107374182;
			K_W'(21): r = 32'd102261126;
			K_W'(22): r = 32'd97612893;
			K_W'(23): r = 32'd93368854;
			K_W'(24): r = 32'd89478485;
			K_W'(25): r = 32'd85899346;
			K_W'(26): r = 32'd82595525;
			K_W'(27): r = 32'd79536431;
			K_W'(28): r = 32'd76695845;
			K_W'(29): r = 32'd74051160;
			K_W'(30): r = 32'd71582788;
			K_W'(31): r = 32'd69273666;
			default:  r = '0;
		endcase
		return r;
	endfunction

	// One control word per step. One term takes steps 1..7; step 7 also starts
	// the next term's first multiply, so step 0 runs only for the first term.
	function automatic tea_cw_t tea_ucode(input logic [PC_W-1:0] pc);
		tea_cw_t cw;
		cw.mul     = MUL_NONE;
		cw.alu     = ALU_NONE;
		cw.term_en = 1'b0;
		cw.sum_en  = 1'b0;
		cw.loop    = 1'b0;
		cw.fin     = 1'b0;
		case (pc)
			PC_W'(0): begin
				cw.mul = MUL_TLO;
			end
			PC_W'(1): begin
				cw.mul = MUL_THI;
				cw.alu = ALU_LOAD_TX;
			end
			PC_W'(2): begin
				cw.alu = ALU_ADD_TX;
			end
			PC_W'(3): begin
				cw.mul = MUL_PLO;
			end
			PC_W'(4): begin
				cw.mul = MUL_PHI;
				cw.alu = ALU_LOAD_RC;
			end
			PC_W'(5): begin
				cw.alu = ALU_ADD_RC;
			end
			PC_W'(6): begin
				cw.term_en = 1'b1;
			end
			PC_W'(7): begin
				cw.sum_en = 1'b1;
				cw.mul    = MUL_TLO;
				cw.loop   = 1'b1;
			end
			PC_W'(8): begin
				cw.fin = 1'b1;
			end
			default: begin
				cw.fin = 1'b1;
			end
		endcase
		return cw;
	endfunction

endpackage

/* hw/rtl/taylor_exp_approximator.sv */
// Truncated Taylor series of exp(x): microcode sequencer, datapath and result register.
// Depends on tea_pkg.sv and taylor_exp_approximator_assert.svh.
//
// Usage:
//  - Request channel req (req_valid/req_stall) carries x in Q8.24 and a term
//    count n; the response channel rsp (rsp_valid/rsp_stall) returns the
//    saturated Q40.24 sum with error and overflow flags. One response per request.
//  - Counts above 32 are clamped to 32; a count of zero returns 0 with
//    count_error set.
//  - One item at a time. Each term runs seven microcode steps on one shared
//    36x32 multiplier (term*x in two halves, then times 1/k in two halves).
//    For n <= 1 the item goes straight to its final step. The next request is
//    taken in the cycle after the result reaches the output register.
//  - The result sits in an output register; req_stall drops while it waits
//    there, so a new item can start under a stalled response. A finished item
//    holds in its last step until the output register is free.
//  - Reset (arst_n low) empties the block: rsp_valid low, req_stall low.
`timescale 1ns / 1ps
`include "taylor_exp_approximator_assert.svh"

module taylor_exp_approximator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  tea_pkg::tea_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output tea_pkg::tea_rsp_t rsp
);

	localparam logic [tea_pkg::ACC_W-1:0] TX_HALF =
		tea_pkg::ACC_W'(1) << (tea_pkg::FRAC_BITS - 1);
	localparam logic [tea_pkg::ACC_W-1:0] RC_HALF =
		tea_pkg::ACC_W'(1) << (tea_pkg::RCP_FRAC - 1);
	localparam logic [tea_pkg::TERM_W-1:0] ONE_FX =
		tea_pkg::TERM_W'(1) << tea_pkg::FRAC_BITS;
	localparam logic [tea_pkg::TERM_W-1:0] POS_MAX =
		{1'b0, {(tea_pkg::TERM_W-1){1'b1}}};
	localparam logic [tea_pkg::TERM_W-1:0] NEG_MIN =
		{1'b1, {(tea_pkg::TERM_W-1){1'b0}}};

	// Control
	logic                        busy_q;
	logic [tea_pkg::PC_W-1:0]    pc_q;
	logic [tea_pkg::K_W-1:0]     k_q;
	logic [tea_pkg::K_W-1:0]     n_q;
	logic                        err_q;
	logic                        ovf_q;
	logic                        rsp_valid_q;
	tea_pkg::tea_rsp_t           rsp_q;
	tea_pkg::tea_cw_t            cw;

	// Datapath
	logic [tea_pkg::X_W-1:0]     xmag_q;
	logic                        xneg_q;
	logic [tea_pkg::TERM_W-1:0]  tmag_q;
	logic                        tneg_q;
	logic [tea_pkg::TERM_W-1:0]  sum_q;
	logic [tea_pkg::MP_W-1:0]    prod_q;
	logic [tea_pkg::ACC_W-1:0]   acc_q;
	logic [tea_pkg::P1_W-1:0]    p1_q;
	logic [tea_pkg::Q_W-1:0]     q_q;

	logic                        req_xfer;
	logic                        out_free;
	logic [tea_pkg::K_W-1:0]     n_clamp;
	logic [tea_pkg::X_W-1:0]     x_bits;
	logic [tea_pkg::MA_W-1:0]    mul_a;
	logic [tea_pkg::RCP_W-1:0]   mul_b;
	logic [tea_pkg::MP_W-1:0]    mul_p;
	logic [tea_pkg::S1_W-1:0]    s1;
	logic [tea_pkg::S2_W-1:0]    s2;
	logic                        t_neg;
	logic [tea_pkg::TERM_W-1:0]  t_limit;
	logic                        t_big;
	logic [tea_pkg::TERM_W-1:0]  t_mag;
	logic [tea_pkg::TERM_W-1:0]  addend;
	logic [tea_pkg::TERM_W-1:0]  s_sum;
	logic                        s_ovf;

	assign req_stall = busy_q;
	assign req_xfer  = req_valid && !busy_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cw        = tea_pkg::tea_ucode(pc_q);

	// Clamp the count and take the magnitude of x
	assign n_clamp = (req.term_count > tea_pkg::CNT_W'(tea_pkg::MAX_TERMS)) ?
		tea_pkg::K_W'(tea_pkg::MAX_TERMS) : tea_pkg::K_W'(req.term_count);
	assign x_bits  = req.arg_x;

	// Select multiplier operands
	always_comb begin
		case (cw.mul)
			tea_pkg::MUL_TLO: mul_a = tea_pkg::MA_W'(tmag_q[31:0]);
			tea_pkg::MUL_THI: mul_a = tea_pkg::MA_W'(tmag_q[63:32]);
			tea_pkg::MUL_PLO: mul_a = p1_q[tea_pkg::MA_W-1:0];
			tea_pkg::MUL_PHI: mul_a = tea_pkg::MA_W'(p1_q >> tea_pkg::MA_W);
			default:          mul_a = '0;
		endcase
	end

	always_comb begin
		case (cw.mul)
			tea_pkg::MUL_PLO, tea_pkg::MUL_PHI: mul_b = tea_pkg::tea_recip(k_q);
			default:                            mul_b = xmag_q;
		endcase
	end

	assign mul_p = tea_pkg::MP_W'(mul_a) * tea_pkg::MP_W'(mul_b);

	// Combine the two partial products of each multiply
	assign s1 = tea_pkg::S1_W'(acc_q) + (tea_pkg::S1_W'(prod_q) << tea_pkg::X_W);
	assign s2 = tea_pkg::S2_W'(acc_q) + (tea_pkg::S2_W'(prod_q) << tea_pkg::MA_W);

	// Saturate the new term magnitude
	assign t_neg   = tneg_q ^ xneg_q;
	assign t_limit = t_neg ? NEG_MIN : POS_MAX;
	assign t_big   = q_q > tea_pkg::Q_W'(t_limit);
	assign t_mag   = t_big ? t_limit : q_q[tea_pkg::TERM_W-1:0];

	// Signed saturating sum: negate the term through invert plus carry-in
	assign addend = tmag_q ^ {tea_pkg::TERM_W{tneg_q}};
	assign s_sum  = sum_q + addend + tea_pkg::TERM_W'(tneg_q);
	assign s_ovf  = (sum_q[tea_pkg::TERM_W-1] == tneg_q) &&
		(s_sum[tea_pkg::TERM_W-1] != sum_q[tea_pkg::TERM_W-1]);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= tea_pkg::PC_START;
			k_q         <= '0;
			n_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Raise on a finished item, hold while stalled, drop after the transfer
			rsp_valid_q <= (busy_q && cw.fin && out_free) || (rsp_valid_q && rsp_stall);
			if (req_xfer) begin
				busy_q <= 1'b1;
				k_q    <= tea_pkg::K_W'(1);
				n_q    <= n_clamp;
				pc_q   <= (n_clamp <= tea_pkg::K_W'(1)) ? tea_pkg::PC_FIN : tea_pkg::PC_START;
			end else if (busy_q) begin
				if (cw.term_en) begin
					k_q <= k_q + tea_pkg::K_W'(1);
				end
				if (cw.fin) begin
					if (out_free) begin
						busy_q <= 1'b0;
					end
				end else if (cw.loop && (k_q != n_q)) begin
					pc_q <= tea_pkg::PC_LOOP;
				end else begin
					pc_q <= pc_q + tea_pkg::PC_W'(1);
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tneg_q <= 1'b0;
			err_q  <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (req_xfer) begin
			xneg_q <= x_bits[tea_pkg::X_W-1];
			xmag_q <= x_bits[tea_pkg::X_W-1] ? (~x_bits + tea_pkg::X_W'(1)) : x_bits;
			tmag_q <= ONE_FX;
			tneg_q <= 1'b0;
			sum_q  <= (n_clamp == '0) ? '0 : ONE_FX;
			err_q  <= (n_clamp == '0);
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			if (cw.mul != tea_pkg::MUL_NONE) begin
				prod_q <= mul_p;
			end
			case (cw.alu)
				tea_pkg::ALU_LOAD_TX: acc_q <= tea_pkg::ACC_W'(prod_q) + TX_HALF;
				tea_pkg::ALU_ADD_TX:  p1_q  <= s1[tea_pkg::FRAC_BITS +: tea_pkg::P1_W];
				tea_pkg::ALU_LOAD_RC: acc_q <= tea_pkg::ACC_W'(prod_q) + RC_HALF;
				tea_pkg::ALU_ADD_RC:  q_q   <= s2[tea_pkg::RCP_FRAC +: tea_pkg::Q_W];
				default: begin
				end
			endcase
			if (cw.term_en) begin
				tmag_q <= t_mag;
				tneg_q <= t_neg && (t_mag != '0);
				if (t_big) begin
					ovf_q <= 1'b1;
				end
			end
			if (cw.sum_en) begin
				if (s_ovf) begin
					sum_q <= sum_q[tea_pkg::TERM_W-1] ? NEG_MIN : POS_MAX;
					ovf_q <= 1'b1;
				end else begin
					sum_q <= s_sum;
				end
			end
		end
	end

	// Load the result
	always_ff @(posedge clk) begin
		if (busy_q && cw.fin && out_free && !req_xfer) begin
			rsp_q.approx      <= err_q ? '0 : sum_q;
			rsp_q.count_error <= err_q;
			rsp_q.overflowed  <= err_q ? 1'b0 : ovf_q;
		end
	end

	`TEA_ASSERT_NXT(a_xfer_busy, clk, arst_n, req_xfer, busy_q, "transfer did not start an item")
	`TEA_ASSERT_IMP(a_k_range, clk, arst_n, busy_q && (n_q != '0), k_q <= n_q, "term index passed the count")
	`TEA_ASSERT_IMP(a_neg_zero, clk, arst_n, tneg_q, tmag_q != '0, "negative zero term")
	`TEA_ASSERT_IMP(a_err_rsp, clk, arst_n, rsp_valid_q && rsp_q.count_error,
		rsp_q.approx == '0 && !rsp_q.overflowed, "count error with nonzero result")

endmodule
